[rtl/assert_macros.svh]
// concurrent assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/stff_pkg.sv]
// types and constants of the slot table allocator
package stff_pkg;

  localparam int unsigned SLOT_W = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned STAT_W = 3;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_INSERT_AT = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_GET       = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_OCCUPIED = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_RANGE    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0] entry_data;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] result_slot;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  high_water;
  } rsp_t;

endpackage

[rtl/stff_ram.sv]
// generic simple dual-port ram with registered read
module stff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/slot_table_first_free_alloc_unit.sv]
// top level of the slot table allocator: command fsm, in-use bits, bound and data ram
`include "assert_macros.svh"

// Slot table with first-free allocation. A command is taken when start_i is high and busy_o
// is low. In the accept cycle the data ram is read at the addressed slot; in the exec state
// (busy_o high) the in-use bits are searched by a priority encoder, the command is resolved
// and the ram and the in-use bits are written back. The result strobes on res_valid_o for
// exactly one cycle right after that; busy_o is already low then, so the next command may be
// accepted in that same cycle. No new command is taken while one is in the exec state, which
// is there because the data ram read is registered. The receiver cannot stall: a result not
// taken in its strobe cycle is gone. The in-use bits are flip-flops cleared by reset, so no
// clearing pass runs and a command may start right after reset. The user must write slot_count
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
module slot_table_first_free_alloc_unit #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  stff_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output stff_pkg::rsp_t                res_o,
  input  logic                          cfg_we_i,
  input  logic [stff_pkg::CNT_W-1:0]    cfg_wdata_i
);

  import stff_pkg::*;

  // address width of the table, and a count width that holds both slot_count and DEPTH
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = ($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W;

  // control state
  state_e            state_q, state_d;
  logic              accept;
  logic              exec;

  // latched command and configuration
  req_t              req_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  bound_q, bound_d;
  logic [DEPTH-1:0]  used_q;

  // result register
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q;

  // data ram interface
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // evaluation signals
  logic [CW-1:0]     n_c;
  logic [CW-1:0]     idx_c;
  logic [AW-1:0]     idx_a;
  logic              in_rng;
  logic              used_at;
  logic              ff_found;
  logic [AW-1:0]     ff_idx;
  logic              claim_en;
  logic [AW-1:0]     claim_idx;
  logic              clr_en;

  // ---------------------------------------------------------------------------
  // command fsm
  // ---------------------------------------------------------------------------

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o = 1'b0;
    exec   = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        exec   = 1'b0;
      end
      S_EXEC: begin
        busy_o = 1'b1;
        exec   = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
        exec   = 1'b0;
      end
    endcase
  end

  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // data ram: read issued in the accept cycle, written back in the exec cycle
  // ---------------------------------------------------------------------------

  // read every cycle at the incoming index; only the accept-cycle read is used
  assign ram_raddr = AW'(req_i.slot_index);
  assign ram_we    = exec && claim_en;
  assign ram_waddr = claim_idx;
  assign ram_wdata = DATA_WIDTH'(req_q.entry_data);

  stff_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // command evaluation
  // ---------------------------------------------------------------------------

  // usable slots: slot_count limited to the table depth
  assign n_c    = (CW'(count_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(count_q);
  assign idx_c  = CW'(req_q.slot_index);
  assign idx_a  = AW'(req_q.slot_index);
  assign in_rng = idx_c < n_c;
  // only looked at when the index is in range
  assign used_at = used_q[idx_a];

  // lowest free slot below the usable size
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!used_q[i] && (CW'(i) < n_c)) begin
        ff_found = 1'b1;
        ff_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    rsp_d             = '0;
    rsp_d.status      = STAT_OK;
    rsp_d.result_slot = req_q.slot_index;
    rsp_d.read_data   = '0;
    claim_en          = 1'b0;
    claim_idx         = idx_a;
    clr_en            = 1'b0;

    if (req_q.cmd == CMD_INSERT) begin
      if (ff_found) begin
        claim_en          = 1'b1;
        claim_idx         = ff_idx;
        rsp_d.result_slot = SLOT_W'(ff_idx);
      end else begin
        rsp_d.status      = STAT_FULL;
        rsp_d.result_slot = '0;
      end
    end else if (!in_rng) begin
      rsp_d.status = STAT_RANGE;
    end else begin
      case (req_q.cmd)
        CMD_INSERT_AT: begin
          if (used_at) begin
            rsp_d.status = STAT_OCCUPIED;
          end else begin
            claim_en = 1'b1;
          end
        end
        CMD_DELETE: begin
          clr_en = 1'b1;
        end
        CMD_GET: begin
          if (used_at) begin
            rsp_d.read_data = DATA_W'(ram_rdata);
          end else begin
            rsp_d.status = STAT_EMPTY;
          end
        end
        default: begin
          rsp_d.status = STAT_OK;
        end
      endcase
    end

    // high-water bound: up on a claim exactly at the bound, down on delete just below it
    bound_d = bound_q;
    if (claim_en && (CW'(claim_idx) == CW'(bound_q))) begin
      bound_d = bound_q + CNT_W'(1);
    end else if (clr_en && (bound_q != '0) && (idx_c == CW'(bound_q - CNT_W'(1)))) begin
      bound_d = bound_q - CNT_W'(1);
    end
    rsp_d.high_water = bound_d;
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= SLOT_COUNT_RST;
      bound_q     <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= exec;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (exec) begin
        bound_q <= bound_d;
        if (claim_en) begin
          used_q[claim_idx] <= 1'b1;
        end
        if (clr_en) begin
          used_q[idx_a] <= 1'b0;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign res_valid_o = rsp_valid_q;
  assign res_o       = rsp_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // every evaluated command strobes exactly one result in the next cycle
  `ASSERT_NEXT(a_rsp_after_exec, clk_i, rst_ni, state_q == S_EXEC, res_valid_o)
  // a result strobe only ever shows while the fsm is back in idle
  `ASSERT_IMP(a_rsp_in_idle, clk_i, rst_ni, res_valid_o, state_q == S_IDLE && !busy_o)
  // the bound never passes the table depth
  `ASSERT_IMP(a_bound_le_depth, clk_i, rst_ni, 1'b1, CW'(bound_q) <= CW'(DEPTH))

endmodule

[tb/slot_table_first_free_alloc_unit_checker.sv]
// checker for the slot table allocator: predicts each command and compares its result
`timescale 1ns / 100ps

module slot_table_first_free_alloc_unit_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  stff_pkg::req_t             req_i,
  input  logic                       res_valid_i,
  input  stff_pkg::rsp_t             res_i,
  input  logic                       cfg_we_i,
  input  logic [stff_pkg::CNT_W-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import stff_pkg::*;

  logic [DEPTH-1:0]       in_use_bits;
  logic [DATA_W-1:0]      slot_words [DEPTH];
  logic [CNT_W-1:0]       bound_q;
  logic [CNT_W-1:0]       slot_limit;
  rsp_t                   table_rsp_q [$];
  rsp_t                   want_rsp;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    in_use_bits = '0;
    bound_q = '0;
    slot_limit = SLOT_COUNT_RST;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count_o++;
  endtask

  // claim a slot: mark it used, store the word, raise the bound when claimed at the bound
  function automatic void claim_slot(input int unsigned idx, input logic [DATA_W-1:0] data);
    in_use_bits[idx] = 1'b1;
    slot_words[idx] = data;
    if (idx == int'(bound_q)) bound_q = bound_q + 1'b1;
  endfunction

  function automatic rsp_t resolve_table_cmd(input req_t req);
    rsp_t        rsp;
    int unsigned usable;
    bit          found;
    usable = (int'(slot_limit) > DEPTH) ? DEPTH : int'(slot_limit);
    rsp.status = STAT_OK;
    rsp.result_slot = req.slot_index;
    rsp.read_data = '0;
    found = 1'b0;
    if (req.cmd == CMD_INSERT) begin
      rsp.status = STAT_FULL;
      rsp.result_slot = '0;
      for (int unsigned i = 0; i < usable; i++) begin
        if (!found && !in_use_bits[i]) begin
          found = 1'b1;
          claim_slot(i, req.entry_data);
          rsp.status = STAT_OK;
          rsp.result_slot = i[SLOT_W-1:0];
        end
      end
    end else if (int'(req.slot_index) >= usable) begin
      rsp.status = STAT_RANGE;
    end else begin
      case (req.cmd)
        CMD_INSERT_AT: begin
          if (in_use_bits[req.slot_index]) rsp.status = STAT_OCCUPIED;
          else claim_slot(req.slot_index, req.entry_data);
        end
        CMD_DELETE: begin
          if (bound_q != 0 && int'(req.slot_index) == int'(bound_q) - 1)
            bound_q = bound_q - 1'b1;
          in_use_bits[req.slot_index] = 1'b0;
        end
        default: begin
          if (in_use_bits[req.slot_index]) rsp.read_data = slot_words[req.slot_index];
          else rsp.status = STAT_EMPTY;
        end
      endcase
    end
    rsp.high_water = bound_q;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_bits = '0;
      bound_q = '0;
      slot_limit = SLOT_COUNT_RST;
      table_rsp_q.delete();
    end else begin
      if (res_valid_i) begin
        if (table_rsp_q.size() == 0) begin
          report_mismatch($sformatf("result with no command outstanding (slot %0d)",
                                    res_i.result_slot));
        end else begin
          want_rsp = table_rsp_q.pop_front();
          if (res_i.status !== want_rsp.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      res_i.status, want_rsp.status));
          if (res_i.result_slot !== want_rsp.result_slot)
            report_mismatch($sformatf("result_slot got %0d want %0d",
                                      res_i.result_slot, want_rsp.result_slot));
          if (res_i.read_data !== want_rsp.read_data)
            report_mismatch($sformatf("read_data got %08h want %08h",
                                      res_i.read_data, want_rsp.read_data));
          if (res_i.high_water !== want_rsp.high_water)
            report_mismatch($sformatf("high_water got %0d want %0d",
                                      res_i.high_water, want_rsp.high_water));
        end
      end
      if (cfg_we_i) slot_limit = cfg_wdata_i;
      if (start_i && !busy_i) table_rsp_q.push_back(resolve_table_cmd(req_i));
    end
    pending_o = table_rsp_q.size();
  end

endmodule

[tb/slot_table_first_free_alloc_unit_test.sv]
// testbench top for the slot table allocator: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module slot_table_first_free_alloc_unit_test;
  import stff_pkg::*;

  // cycles with no transaction on either side before the run is declared hung
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 235;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  req_t                req_i;
  logic                res_valid_o;
  rsp_t                res_o;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_wdata_i;

  int                  fail_count;
  int                  pending;
  int                  quiet_cycles;
  int unsigned         idle_pct;       // chance in percent of a gap before each command
  logic [CNT_W-1:0]    cur_count;      // slot_count as last written

  slot_table_first_free_alloc_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  slot_table_first_free_alloc_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: any accepted command or any result strobe counts as progress
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one command transaction; called at a falling edge, returns at the falling edge after
  // acceptance with start_i still high, so back-to-back commands never re-toggle it
  task automatic send_cmd(input cmd_e cmd, input logic [SLOT_W-1:0] idx,
                          input logic [DATA_W-1:0] data);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{cmd: cmd, slot_index: idx, entry_data: data};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // slot_count may only change with the block idle: drop start, drain, then write
  task automatic set_slot_count(input logic [CNT_W-1:0] count);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    cur_count = count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random command: weighted toward inserts and deletes so the table fills and drains,
  // with most indexes inside the usable range and some anywhere
  task automatic send_random_cmd();
    int unsigned  pick;
    int unsigned  usable;
    cmd_e         cmd;
    logic [SLOT_W-1:0] idx;
    usable = (cur_count > 64) ? 64 : cur_count;
    pick = $urandom_range(99, 0);
    if (pick < 35) cmd = CMD_INSERT;
    else if (pick < 50) cmd = CMD_INSERT_AT;
    else if (pick < 75) cmd = CMD_DELETE;
    else cmd = CMD_GET;
    if (usable > 0 && $urandom_range(9, 0) < 8) idx = SLOT_W'($urandom_range(usable - 1, 0));
    else idx = SLOT_W'($urandom_range(63, 0));
    send_cmd(cmd, idx, $urandom());
  endtask

  logic [CNT_W-1:0] phase_count [8];
  int unsigned      phase_idle [4];

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = SLOT_COUNT_RST;
    cur_count = SLOT_COUNT_RST;
    idle_pct = 0;
    // settings walked through by the random part; 127 is beyond the table depth
    phase_count = '{7'd64, 7'd1, 7'd127, 7'd7, 7'($urandom_range(63, 2)), 7'd64, 7'd2, 7'd40};
    // no gaps, heavy gaps, no gaps (the result side cannot stall), light gaps
    phase_idle = '{0, 72, 0, 22};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at the reset size of 64
    send_cmd(CMD_DELETE, 6'd0, 32'h0);              // delete of a free slot, bound at zero
    send_cmd(CMD_GET, 6'd0, 32'h0);                 // empty slot
    send_cmd(CMD_GET, 6'd63, 32'hffff_ffff);        // empty slot, top index
    send_cmd(CMD_INSERT, 6'd0, 32'hffff_ffff);      // lowest free slot, bound rises
    send_cmd(CMD_INSERT, 6'd63, 32'h0);
    send_cmd(CMD_INSERT_AT, 6'd63, 32'ha5a5_5a5a);  // claim above the bound
    send_cmd(CMD_INSERT_AT, 6'd0, 32'h1111_1111);   // occupied
    send_cmd(CMD_GET, 6'd0, 32'h0);
    send_cmd(CMD_GET, 6'd63, 32'h0);
    send_cmd(CMD_DELETE, 6'd1, 32'h0);              // just below the bound, bound falls
    send_cmd(CMD_DELETE, 6'd63, 32'h0);
    send_cmd(CMD_INSERT_AT, 6'd1, 32'h1234_5678);   // claim exactly at the bound

    // two usable slots, both used: full and out of range
    set_slot_count(7'd2);
    send_cmd(CMD_INSERT, 6'd5, 32'hdead_beef);
    send_cmd(CMD_INSERT_AT, 6'd2, 32'h0);
    send_cmd(CMD_DELETE, 6'd63, 32'h0);
    send_cmd(CMD_GET, 6'd5, 32'h0);

    // no usable slot at all
    set_slot_count(7'd0);
    send_cmd(CMD_INSERT, 6'd0, 32'h0);
    send_cmd(CMD_GET, 6'd0, 32'h0);
    send_cmd(CMD_DELETE, 6'd0, 32'h0);

    // count beyond the depth is limited to the depth
    set_slot_count(7'd127);
    send_cmd(CMD_INSERT, 6'd0, 32'h8000_0001);
    send_cmd(CMD_GET, 6'd63, 32'h0);
    send_cmd(CMD_INSERT_AT, 6'd63, 32'h7fff_fffe);
    send_cmd(CMD_GET, 6'd63, 32'h0);

    // random part in phases of size and gap setting
    for (int p = 0; p < 8; p++) begin
      set_slot_count(phase_count[p]);
      idle_pct = phase_idle[p % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_cmd();
    end

    // drain and let the pipeline settle before the verdict
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
